// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while reset is asserted.
`define PEDD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// A signal keeps its value in the cycle after the condition held.
`define PEDD_ASSERT_HOLD(lbl, clk, rstn, cond, sig) \
  `PEDD_ASSERT(lbl, clk, rstn, (cond) |=> $stable(sig))

`endif

// File: rtl/pedd_pkg.sv
// Package with the constants and types of the palette dither.
`timescale 1ns / 1ps
package pedd_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int CAND_DEPTH  = 32768;
  localparam int CAND_AW     = $clog2(CAND_DEPTH);
  localparam int CELLS       = 4096;
  localparam int PAL_DEPTH   = 256;
  localparam int ERROR_BITS  = 12;
  localparam int ERR_WORD_W  = 3 * ERROR_BITS;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT = 1'd1;
  localparam logic [11:0] WIDTH_RESET = 12'd640;
  localparam logic [7:0]  CLAMP_RESET = 8'd32;

  localparam logic [2:0] OP_PIXEL = 3'd0;
  localparam logic [2:0] OP_PAL   = 3'd1;
  localparam logic [2:0] OP_CELL  = 3'd2;
  localparam logic [2:0] OP_CAND  = 3'd3;
  localparam logic [2:0] OP_FRAME = 3'd4;

  typedef enum logic [2:0] {
    KIND_PIXEL,
    KIND_PAL,
    KIND_CELL,
    KIND_CAND,
    KIND_FRAME
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [14:0] address;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] table_data;
  } work_t;

endpackage

// File: rtl/pedd_if.sv
// Stream interfaces for the input and result words of the palette dither.
`timescale 1ns / 1ps
interface pedd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [14:0] address;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] table_data;
  modport source (output valid, operation, address, red, green, blue, table_data,
                  input ready);
  modport sink (input valid, operation, address, red, green, blue, table_data,
                output ready);
endinterface

interface pedd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] palette_index;
  logic       row_end;
  modport source (output valid, palette_index, row_end, input ready);
  modport sink (input valid, palette_index, row_end, output ready);
endinterface

// File: rtl/pedd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pedd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: rtl/pedd_front.sv
// Front end: takes input words, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module pedd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  pedd_in_if.sink        in_if,
  input  logic           hold_i,
  output pedd_pkg::work_t work_o,
  output logic           work_valid_o,
  input  logic           work_pop_i
);
  import pedd_pkg::*;

  work_t      ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       accept, known, push, pop;
  kind_e      kind;

  assign in_if.ready = (cnt_q != 2'd2) && !hold_i;
  assign accept      = in_if.valid && in_if.ready;

  // Unknown operations are consumed and dropped here.
  always_comb begin
    known = 1'b1;
    kind  = KIND_PIXEL;
    case (in_if.operation)
      OP_PIXEL: kind = KIND_PIXEL;
      OP_PAL:   kind = KIND_PAL;
      OP_CELL:  kind = KIND_CELL;
      OP_CAND:  kind = KIND_CAND;
      OP_FRAME: kind = KIND_FRAME;
      default:  known = 1'b0;
    endcase
  end

  assign push         = accept && known;
  assign work_valid_o = (cnt_q != 2'd0);
  assign pop          = work_pop_i && work_valid_o;
  assign work_o       = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= '{kind: kind, address: in_if.address, red: in_if.red,
                           green: in_if.green, blue: in_if.blue,
                           table_data: in_if.table_data};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: rtl/pedd_back.sv
// Back end: table writes, candidate walk, error diffusion and the result register.
`timescale 1ns / 1ps
module pedd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pedd_pkg::work_t work_i,
  input  logic            work_valid_i,
  output logic            work_pop_o,
  output logic            clearing_o,
  input  logic [11:0]     image_width_i,
  input  logic [7:0]      clamp_limit_i,
  pedd_out_if.source      out_if
);
  import pedd_pkg::*;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_PREP  = 4'd2;
  localparam logic [3:0] ST_OFF   = 4'd3;
  localparam logic [3:0] ST_CNT   = 4'd4;
  localparam logic [3:0] ST_WALK  = 4'd5;
  localparam logic [3:0] ST_ERR0  = 4'd6;
  localparam logic [3:0] ST_ERR1  = 4'd7;
  localparam logic [3:0] ST_ERR2  = 4'd8;
  localparam logic [3:0] ST_ERR3  = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [COL_W-1:0] clr_q, col_q, pcol_q;
  logic             last_q;
  logic signed [ERROR_BITS-1:0] rc_q [3];
  logic signed [ERROR_BITS-1:0] bc_q [3];
  logic signed [ERROR_BITS-1:0] old_q [3];
  logic signed [9:0]  want_q [3];
  logic [7:0]         tgt_q [3];
  logic [7:0]         best_rgb_q [3];
  logic signed [10:0] e_q [3];
  logic signed [8:0]  qe_q [3];
  logic [CAND_AW-1:0] base_q;
  logic [8:0]         n_q, issue_q;
  logic               v1_q, v2_q, f1_q, f2_q;
  logic [7:0]         idx2_q, best_idx_q;
  logic [9:0]         best_d_q;
  logic               out_valid_q;
  logic [7:0]         out_idx_q;
  logic               out_row_q;

  // RAM ports
  logic                  pal_we;
  logic [23:0]           pal_rdata;
  logic [7:0]            pal_raddr;
  logic                  off_we;
  logic [15:0]           off_rdata;
  logic [11:0]           off_raddr;
  logic                  cand_we;
  logic [7:0]            cand_rdata;
  logic [CAND_AW-1:0]    cand_raddr;
  logic                  err_we;
  logic [COL_W-1:0]      err_waddr, err_raddr;
  logic [ERR_WORD_W-1:0] err_wdata, err_rdata;

  logic        take;
  logic [11:0] w_eff;
  logic [COL_W-1:0] pcol;
  logic        last;
  logic signed [12:0] esum, lim, ein;
  logic signed [12:0] wsum [3];
  logic [9:0]  cand_dist;
  logic [8:0]  cnt_eff;
  logic        walk_done, can_load;

  assign take       = (state_q == ST_IDLE) && work_valid_i;
  assign work_pop_o = take;
  assign clearing_o = (state_q == ST_CLEAR);

  // Column handling: width of zero acts as one, stale columns restart at zero.
  always_comb begin
    w_eff = (image_width_i == 12'd0) ? 12'd1 : image_width_i;
    if (image_width_i > 12'(MAX_WIDTH - 1)) begin
      w_eff = 12'(MAX_WIDTH - 1);
    end
    pcol = (12'(col_q) >= w_eff) ? '0 : col_q;
    last = ({1'b0, 12'(pcol)} + 13'd1) >= {1'b0, w_eff};
  end

  // Incoming error per channel, clamped, added to the pixel.
  always_comb begin
    lim = $signed({5'b0, clamp_limit_i});
    for (int c = 0; c < 3; c++) begin
      esum = 13'(rc_q[c]) + 13'(bc_q[c]);
      if (esum > lim) begin
        ein = lim;
      end else if (esum < -lim) begin
        ein = -lim;
      end else begin
        ein = esum;
      end
      wsum[c] = ein + $signed({5'b0, (c == 0) ? work_i.red :
                                     (c == 1) ? work_i.green : work_i.blue});
    end
  end

  // L1 distance of the palette entry read for the current candidate.
  always_comb begin
    cand_dist = '0;
    for (int c = 0; c < 3; c++) begin
      logic signed [9:0] diff;
      diff = $signed({2'b0, tgt_q[c]}) - $signed({2'b0, pal_rdata[8*c +: 8]});
      cand_dist = cand_dist + ((diff < 0) ? 10'(-diff) : 10'(diff));
    end
  end

  assign cnt_eff   = (cand_rdata == 8'd0) ? 9'd1 : {1'b0, cand_rdata};
  assign walk_done = (issue_q == n_q) && !v1_q && !v2_q;
  assign can_load  = !out_valid_q || out_if.ready;

  // Read address selection.
  always_comb begin
    off_raddr  = {tgt_q[2][7:4], tgt_q[1][7:4], tgt_q[0][7:4]};
    cand_raddr = (state_q == ST_OFF) ? off_rdata[CAND_AW-1:0]
                                     : base_q + CAND_AW'(issue_q) + CAND_AW'(1);
    pal_raddr  = cand_rdata;
    err_raddr  = (state_q == ST_ERR1) ? pcol_q + COL_W'(1) : pcol_q;
  end

  // Table writes straight from the queue head.
  assign pal_we  = take && (work_i.kind == KIND_PAL) && (work_i.address < 15'(PAL_DEPTH));
  assign off_we  = take && (work_i.kind == KIND_CELL) && (work_i.address < 15'(CELLS));
  assign cand_we = take && (work_i.kind == KIND_CAND) &&
                   ({1'b0, work_i.address} < 16'(CAND_DEPTH));

  always_comb begin
    err_we    = 1'b0;
    err_waddr = pcol_q;
    err_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        err_we    = 1'b1;
        err_waddr = clr_q;
      end
      ST_ERR2: begin
        err_we = 1'b1;
        for (int c = 0; c < 3; c++) begin
          err_wdata[ERROR_BITS*c +: ERROR_BITS] = old_q[c] + ERROR_BITS'(qe_q[c]);
        end
      end
      ST_ERR3: begin
        err_we    = 1'b1;
        err_waddr = pcol_q + COL_W'(1);
        for (int c = 0; c < 3; c++) begin
          err_wdata[ERROR_BITS*c +: ERROR_BITS] =
            ERROR_BITS'(e_q[c] - 11'(qe_q[c]) - 11'(qe_q[c]));
        end
      end
      default: err_we = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == COL_W'(MAX_WIDTH - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (take && work_i.kind == KIND_PIXEL) begin
          state_d = ST_PREP;
        end else if (take && work_i.kind == KIND_FRAME) begin
          state_d = ST_CLEAR;
        end
      end
      ST_PREP: state_d = ST_OFF;
      ST_OFF:  state_d = ST_CNT;
      ST_CNT:  state_d = ST_WALK;
      ST_WALK: if (walk_done) state_d = ST_ERR0;
      ST_ERR0: state_d = ST_ERR1;
      ST_ERR1: state_d = ST_ERR2;
      ST_ERR2: state_d = ST_ERR3;
      ST_ERR3: if (can_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int c = 0; c < 3; c++) begin
        want_q[c] <= 10'(wsum[c]);
        tgt_q[c]  <= (wsum[c] < 0) ? 8'd0 : (wsum[c] > 13'sd255) ? 8'd255
                                               : wsum[c][7:0];
      end
      pcol_q <= pcol;
      last_q <= last;
    end
    if (state_q == ST_OFF) begin
      base_q <= off_rdata[CAND_AW-1:0];
    end
    if (state_q == ST_CNT) begin
      n_q <= cnt_eff;
    end
    idx2_q <= cand_rdata;
    if (v2_q && (f2_q || cand_dist < best_d_q)) begin
      best_d_q   <= cand_dist;
      best_idx_q <= idx2_q;
      for (int c = 0; c < 3; c++) begin
        best_rgb_q[c] <= pal_rdata[8*c +: 8];
      end
    end
    if (state_q == ST_ERR0) begin
      for (int c = 0; c < 3; c++) begin
        logic signed [10:0] e;
        logic signed [12:0] p;
        e = 11'(want_q[c]) - $signed({3'b0, best_rgb_q[c]});
        p = 13'(e) + 13'(e) + 13'(e);
        e_q[c]  <= e;
        // Division by eight rounding towards zero.
        qe_q[c] <= 9'((p < 0) ? ((p + 13'sd7) >>> 3) : (p >>> 3));
      end
    end
    if (state_q == ST_ERR1) begin
      for (int c = 0; c < 3; c++) begin
        old_q[c] <= err_rdata[ERROR_BITS*c +: ERROR_BITS];
      end
    end
    if (state_q == ST_ERR3 && can_load) begin
      out_idx_q <= best_idx_q;
      out_row_q <= last_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      col_q       <= '0;
      issue_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      f1_q        <= 1'b0;
      f2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        rc_q[c] <= '0;
        bc_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + COL_W'(1);
      end
      if (take && work_i.kind == KIND_FRAME) begin
        clr_q <= '0;
        col_q <= '0;
        for (int c = 0; c < 3; c++) begin
          rc_q[c] <= '0;
          bc_q[c] <= '0;
        end
      end
      if (state_q == ST_CNT) begin
        issue_q <= '0;
      end
      v1_q <= 1'b0;
      f1_q <= 1'b0;
      if (state_q == ST_WALK && issue_q != n_q) begin
        issue_q <= issue_q + 9'd1;
        v1_q    <= 1'b1;
        f1_q    <= (issue_q == 9'd0);
      end
      v2_q <= v1_q;
      f2_q <= f1_q;
      if (state_q == ST_ERR2) begin
        for (int c = 0; c < 3; c++) begin
          bc_q[c] <= err_rdata[ERROR_BITS*c +: ERROR_BITS];
        end
      end
      if (state_q == ST_ERR3 && can_load) begin
        for (int c = 0; c < 3; c++) begin
          rc_q[c] <= ERROR_BITS'(qe_q[c]);
        end
        col_q <= last_q ? '0 : pcol_q + COL_W'(1);
      end
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_ERR3 && can_load) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.palette_index = out_idx_q;
  assign out_if.row_end       = out_row_q;

  pedd_ram #(.WIDTH(24), .DEPTH(PAL_DEPTH)) u_pal (
    .clk_i, .we_i(pal_we), .waddr_i(work_i.address[7:0]),
    .wdata_i({work_i.blue, work_i.green, work_i.red}),
    .raddr_i(pal_raddr), .rdata_o(pal_rdata)
  );

  pedd_ram #(.WIDTH(16), .DEPTH(CELLS)) u_off (
    .clk_i, .we_i(off_we), .waddr_i(work_i.address[11:0]),
    .wdata_i(work_i.table_data), .raddr_i(off_raddr), .rdata_o(off_rdata)
  );

  pedd_ram #(.WIDTH(8), .DEPTH(CAND_DEPTH)) u_cand (
    .clk_i, .we_i(cand_we), .waddr_i(work_i.address[CAND_AW-1:0]),
    .wdata_i(work_i.table_data[7:0]), .raddr_i(cand_raddr), .rdata_o(cand_rdata)
  );

  pedd_ram #(.WIDTH(ERR_WORD_W), .DEPTH(MAX_WIDTH)) u_err (
    .clk_i, .we_i(err_we), .waddr_i(err_waddr), .wdata_i(err_wdata),
    .raddr_i(err_raddr), .rdata_o(err_rdata)
  );
endmodule

// File: rtl/palette_error_diffusion_dither.sv
// Top level of the palette error-diffusion dither.
`timescale 1ns / 1ps
// Palette error-diffusion dither. Words arrive on the input stream in raster
// order: pixel words produce one palette index word each on the result stream,
// while palette, cell offset and candidate writes and the frame start word
// produce nothing. A pixel stays in the back end from the cycle it is taken
// until its cell's candidate list has been walked (an empty list counts as
// one) and its error terms are written, and its result may wait for the
// previous one to be collected. The walk runs on the single read port of the
// candidate memory, one candidate per cycle, with the palette read and the
// distance compare pipelined behind it. Table writes go straight from the queue.
// A two-word queue sits between the front end and the back end, so words are
// taken while a pixel is in flight and while a finished result waits to be
// collected. After reset, and after every frame start word, the error line
// memory is swept to zero at one entry per cycle, during which the input
// stream is not ready; configuration writes are taken at any time but
// should only be issued while the block is idle.
module palette_error_diffusion_dither (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pedd_in_if.sink                            in_if,
  pedd_out_if.source                         out_if,
  input  logic                               cfg_we_i,
  input  logic [pedd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pedd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import pedd_pkg::*;

  logic [11:0] width_q;
  logic [7:0]  clamp_q;
  work_t       work;
  logic        work_valid, work_pop, clearing;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
      clamp_q <= CLAMP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH: width_q <= cfg_data_i[11:0];
        CFG_CLAMP_LIMIT: clamp_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // The front end classifies words and drops unknown operations.
  pedd_front u_front (
    .clk_i, .rst_ni, .in_if,
    .hold_i(clearing), .work_o(work), .work_valid_o(work_valid), .work_pop_i(work_pop)
  );

  // The back end owns all tables and produces the results.
  pedd_back u_back (
    .clk_i, .rst_ni,
    .work_i(work), .work_valid_i(work_valid), .work_pop_o(work_pop),
    .clearing_o(clearing), .image_width_i(width_q), .clamp_limit_i(clamp_q),
    .out_if
  );
endmodule

// File: rtl/pedd_checker.sv
// Port-level checker for the palette dither, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pedd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_idx,
  input logic       out_row
);
  import pedd_pkg::*;

  logic [2:0] pend_q;
  logic       px_in, px_out;

  assign px_in  = in_valid && in_ready && (in_op == OP_PIXEL);
  assign px_out = out_valid && out_ready;

  // Pixels taken in and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(px_in) - 3'(px_out);
    end
  end

  `PEDD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid)
  `PEDD_ASSERT_HOLD(a_out_stable, clk_i, rst_ni, out_valid && !out_ready, {out_idx, out_row})
  `PEDD_ASSERT(a_no_spurious, clk_i, rst_ni, out_valid |-> pend_q != 3'd0)
  `PEDD_ASSERT(a_clear_after_reset, clk_i, rst_ni, !$past(rst_ni) |-> !in_ready)
endmodule

bind palette_error_diffusion_dither pedd_checker u_pedd_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready), .in_op(in_if.operation),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_idx(out_if.palette_index), .out_row(out_if.row_end)
);

// File: verif/tb_palette_error_diffusion_dither.sv
// Self-checking testbench for the palette error-diffusion dither.
`timescale 1ns / 1ps
module tb_palette_error_diffusion_dither;
  import pedd_pkg::*;

  // Operation codes 5 to 7 are not defined and must be dropped by the block.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  // Number of prepared candidate lists, plus one that runs over the end of the store.
  localparam int LISTS      = 64;
  localparam int LIST_STEP  = 41;
  // Candidate positions below this are filled; every list but the wrapping one lies there.
  localparam int FILL_END   = (LISTS + 1) * LIST_STEP;
  localparam int WRAP_HEAD  = 32760;
  localparam int SETTLE     = 400;

  typedef struct {
    logic [2:0]  op;
    logic [14:0] address;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] table_data;
  } word_t;

  typedef struct {
    logic [7:0] index;
    logic       row_end;
  } choice_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pedd_in_if  in_bus ();
  pedd_out_if out_bus ();

  palette_error_diffusion_dither dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_bus),
    .out_if      (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of everything the block keeps, in the block's own widths.
  logic [7:0]  pal_mem [PAL_DEPTH][3];
  logic [15:0] cell_base [CELLS];
  logic [7:0]  cand_mem [CAND_DEPTH];
  int          err_line [MAX_WIDTH][3];
  int          carry_right [3];
  int          carry_below [3];
  int          cur_col;
  logic [11:0] width_reg;
  logic [7:0]  limit_reg;
  int          list_head [LISTS + 1];

  choice_t choices_due [$];
  int      sender_idle_pct;
  int      receiver_stall_pct;
  int      errors;
  int      pixels_sent;
  int      words_sent;
  int      results_seen;

  // Bring an accumulated error back into ERROR_BITS two's complement.
  function automatic int wrap_err(input int v);
    logic [ERROR_BITS-1:0] u;
    u = v[ERROR_BITS-1:0];
    return int'($signed(u));
  endfunction

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int l1_to(input logic [7:0] idx, input int t [3]);
    int d;
    d = 0;
    for (int c = 0; c < 3; c++) begin
      d += (t[c] > pal_mem[idx][c]) ? t[c] - pal_mem[idx][c] : pal_mem[idx][c] - t[c];
    end
    return d;
  endfunction

  function automatic void clear_frame();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      for (int c = 0; c < 3; c++) err_line[i][c] = 0;
    end
    for (int c = 0; c < 3; c++) begin
      carry_right[c] = 0;
      carry_below[c] = 0;
    end
    cur_col = 0;
  endfunction

  // Dithers one pixel against the shadow state and queues the index it must give.
  function automatic void dither_pixel(input word_t w);
    int          wid, col, lim, base, count, best_d, d, e, q;
    int          want [3];
    int          tgt [3];
    logic [11:0] cell_no;
    logic [7:0]  best, cand;
    choice_t     ch;
    wid = (width_reg == 0) ? 1 : int'(width_reg);
    col = (cur_col >= wid) ? 0 : cur_col;
    lim = int'(limit_reg);
    want[0] = w.red;
    want[1] = w.green;
    want[2] = w.blue;
    for (int c = 0; c < 3; c++) begin
      want[c] += clip(carry_right[c] + carry_below[c], -lim, lim);
      tgt[c] = clip(want[c], 0, 255);
    end
    cell_no = {tgt[2][7:4], tgt[1][7:4], tgt[0][7:4]};
    base = cell_base[cell_no];
    count = cand_mem[base % CAND_DEPTH];
    best = cand_mem[(base + 1) % CAND_DEPTH];
    best_d = l1_to(best, tgt);
    for (int k = 1; k < count; k++) begin
      cand = cand_mem[(base + 1 + k) % CAND_DEPTH];
      d = l1_to(cand, tgt);
      if (d < best_d) begin
        best = cand;
        best_d = d;
      end
    end
    for (int c = 0; c < 3; c++) begin
      e = want[c] - int'(pal_mem[best][c]);
      q = (3 * e) / 8;
      err_line[col][c] = wrap_err(err_line[col][c] + q);
      carry_below[c] = err_line[col + 1][c];
      err_line[col + 1][c] = wrap_err(e - 2 * q);
      carry_right[c] = q;
    end
    ch.index = best;
    ch.row_end = (col + 1 >= wid);
    cur_col = ch.row_end ? 0 : col + 1;
    choices_due.push_back(ch);
  endfunction

  function automatic void apply_word(input word_t w);
    words_sent++;
    case (w.op)
      OP_PIXEL: begin
        pixels_sent++;
        dither_pixel(w);
      end
      OP_PAL: begin
        if (w.address < PAL_DEPTH) begin
          pal_mem[w.address][0] = w.red;
          pal_mem[w.address][1] = w.green;
          pal_mem[w.address][2] = w.blue;
        end
      end
      OP_CELL: if (w.address < CELLS) cell_base[w.address] = w.table_data;
      OP_CAND: cand_mem[w.address] = w.table_data[7:0];
      OP_FRAME: clear_frame();
      default: ;
    endcase
  endfunction

  // Offers one word, idling first at the current rate, and updates the shadow
  // state once the handshake completes.
  task automatic send_word(input word_t w);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= w.op;
    in_bus.address    <= w.address;
    in_bus.red        <= w.red;
    in_bus.green      <= w.green;
    in_bus.blue       <= w.blue;
    in_bus.table_data <= w.table_data;
    // Ready is judged as it stood at the edge itself.
    @(posedge clk_i iff in_bus.ready);
    apply_word(w);
  endtask

  function automatic word_t make_word(input logic [2:0] op, input int addr,
                                      input int r, input int g, input int b,
                                      input int data);
    word_t w;
    w.op = op;
    w.address = addr[14:0];
    w.red = r[7:0];
    w.green = g[7:0];
    w.blue = b[7:0];
    w.table_data = data[15:0];
    return w;
  endfunction

  function automatic word_t random_pixel();
    return make_word(OP_PIXEL, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // A cell offset pointing at one of the prepared lists; bit 15 set at times,
  // which the block must fold back into the store.
  function automatic int random_head();
    int h;
    h = list_head[$urandom_range(LISTS)];
    if (h < 32768 && $urandom_range(1)) h += 32768;
    return h;
  endfunction

  // Lets the stream drain, then waits out the back end before anything is
  // reconfigured.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (choices_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = value[11:0];
    else limit_reg = value[7:0];
  endtask

  // Results are taken at random according to the current stall rate.
  always @(posedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Every result word is held against the oldest outstanding expectation.
  always @(posedge clk_i) begin
    choice_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (choices_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result index %0d row_end %0b", $time,
                 out_bus.palette_index, out_bus.row_end);
      end else begin
        want = choices_due.pop_front();
        if (out_bus.palette_index !== want.index) begin
          errors++;
          $display("%0t: palette_index expected %0d actual %0d", $time,
                   want.index, out_bus.palette_index);
        end
        if (out_bus.row_end !== want.row_end) begin
          errors++;
          $display("%0t: row_end expected %0b actual %0b", $time,
                   want.row_end, out_bus.row_end);
        end
      end
    end
  end

  // Fills every table entry a pixel can reach, so that no pixel ever reads an
  // unwritten one. Lists sit at odd spacings with counts from zero to 32, and
  // one runs off the end of the store.
  task automatic test_table_load();
    int pos;
    for (int i = 0; i < PAL_DEPTH; i++) begin
      send_word(make_word(OP_PAL, i, $urandom, $urandom, $urandom, 0));
    end
    for (int i = 0; i < FILL_END; i++) begin
      send_word(make_word(OP_CAND, i, 0, 0, 0, $urandom));
    end
    for (int k = 0; k < LISTS; k++) begin
      list_head[k] = k * LIST_STEP + 1;
      send_word(make_word(OP_CAND, list_head[k], 0, 0, 0, k % 33));
    end
    list_head[LISTS] = WRAP_HEAD;
    send_word(make_word(OP_CAND, WRAP_HEAD, 0, 0, 0, 20));
    // Palette indices in a list that straddles the end of the store.
    for (int i = 0; i < 24; i++) begin
      pos = (WRAP_HEAD + 1 + i) % CAND_DEPTH;
      send_word(make_word(OP_CAND, pos, 0, 0, 0, $urandom));
    end
    for (int i = 0; i < CELLS; i++) begin
      send_word(make_word(OP_CELL, i, 0, 0, 0, random_head()));
    end
  endtask

  // Colour extremes, both clamp ends, the empty and the wrapping list,
  // ignored writes and operations, and a frame start.
  task automatic test_directed();
    write_reg(CFG_CLAMP_LIMIT, 255);
    write_reg(CFG_IMAGE_WIDTH, 5);
    send_word(make_word(OP_PIXEL, 0, 0, 0, 0, 0));
    send_word(make_word(OP_PIXEL, 0, 255, 255, 255, 0));
    send_word(make_word(OP_PIXEL, 0, 0, 255, 0, 0));
    send_word(make_word(OP_PIXEL, 0, 255, 0, 255, 0));
    send_word(make_word(OP_CELL, 0, 0, 0, 0, list_head[0]));
    send_word(make_word(OP_CELL, 4095, 0, 0, 0, WRAP_HEAD));
    send_word(make_word(OP_PIXEL, 0, 0, 0, 0, 0));
    send_word(make_word(OP_PIXEL, 0, 255, 255, 255, 0));
    send_word(make_word(OP_PAL, 256, 1, 2, 3, 0));
    send_word(make_word(OP_PAL, 32767, 1, 2, 3, 0));
    send_word(make_word(OP_CELL, 4096, 0, 0, 0, 7));
    send_word(make_word(OP_CELL, 32767, 0, 0, 0, 7));
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      send_word(make_word(op[2:0], $urandom, $urandom, $urandom, $urandom, $urandom));
    end
    send_word(make_word(OP_PIXEL, 0, 128, 64, 200, 0));
    send_word(make_word(OP_FRAME, 0, 0, 0, 0, 0));
    send_word(make_word(OP_PIXEL, 0, 255, 0, 0, 0));
    send_word(make_word(OP_PIXEL, 0, 0, 0, 255, 0));
  endtask

  // Widths at both ends and a shrink that strands the column past the new width.
  task automatic test_widths();
    write_reg(CFG_IMAGE_WIDTH, 0);
    repeat (4) send_word(random_pixel());
    write_reg(CFG_IMAGE_WIDTH, 1);
    repeat (4) send_word(random_pixel());
    write_reg(CFG_IMAGE_WIDTH, 9);
    repeat (6) send_word(random_pixel());
    write_reg(CFG_IMAGE_WIDTH, 3);
    repeat (5) send_word(random_pixel());
    write_reg(CFG_CLAMP_LIMIT, 0);
    write_reg(CFG_IMAGE_WIDTH, 4095);
    repeat (10) send_word(random_pixel());
    send_word(make_word(OP_FRAME, 0, 0, 0, 0, 0));
  endtask

  // Mostly pixels, with table rewrites, frame starts and stray
  // operations mixed in; one pause in the middle lets everything drain.
  task automatic test_random(input int words, input int wid, input int lim);
    int roll, a;
    write_reg(CFG_IMAGE_WIDTH, wid);
    write_reg(CFG_CLAMP_LIMIT, lim);
    for (int n = 0; n < words; n++) begin
      if (n == words / 2) begin
        in_bus.valid <= 1'b0;
        while (choices_due.size() != 0) @(posedge clk_i);
      end
      roll = $urandom_range(99);
      if (roll < 80) begin
        send_word(random_pixel());
      end else if (roll < 86) begin
        send_word(make_word(OP_PAL, $urandom_range(299), $urandom, $urandom, $urandom,
                            $urandom));
      end else if (roll < 91) begin
        send_word(make_word(OP_CELL, $urandom_range(4200), 0, 0, 0, random_head()));
      end else if (roll < 97) begin
        // Content bytes only; list counts stay as prepared.
        a = $urandom_range(CAND_DEPTH - 1);
        for (int k = 0; k <= LISTS; k++) if (a == list_head[k]) a = (a + 1) % CAND_DEPTH;
        send_word(make_word(OP_CAND, a, $urandom, $urandom, $urandom, $urandom));
      end else if (roll < 98) begin
        send_word(make_word(OP_FRAME, $urandom, $urandom, $urandom, $urandom, $urandom));
      end else begin
        send_word(make_word(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), $urandom,
                            $urandom, $urandom, $urandom, $urandom));
      end
    end
  endtask

  initial begin
    errors = 0;
    pixels_sent = 0;
    words_sent = 0;
    results_seen = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    in_bus.valid = 1'b0;
    in_bus.operation = OP_PIXEL;
    in_bus.address = '0;
    in_bus.red = '0;
    in_bus.green = '0;
    in_bus.blue = '0;
    in_bus.table_data = '0;
    out_bus.ready = 1'b0;
    width_reg = WIDTH_RESET;
    limit_reg = CLAMP_RESET;
    clear_frame();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_table_load();
    test_directed();
    test_widths();
    sender_idle_pct = 62;
    test_random(190, 7, 32);
    sender_idle_pct = 0;
    receiver_stall_pct = 62;
    test_random(190, 16, 255);
    sender_idle_pct = 9;
    receiver_stall_pct = 9;
    test_random(190, 4095, 1);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    test_random(190, 2, 100);

    drain();
    $display("Covered %0d words, %0d of them pixels, %0d results checked,", words_sent,
             pixels_sent, results_seen);
    $display("over widths 0 to 4095, clamp limits 0 to 255 and four idling mixes.");
    if (errors == 0) begin
      $display("palette_error_diffusion_dither verification clean");
    end else begin
      $display("palette_error_diffusion_dither verification failed");
    end
    $finish;
  end

  // Safety net in case a handshake never completes.
  initial begin
    #40ms;
    $display("palette_error_diffusion_dither verification failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/pedd_pkg.sv
rtl/pedd_if.sv
rtl/pedd_ram.sv
rtl/pedd_front.sv
rtl/pedd_back.sv
rtl/palette_error_diffusion_dither.sv
rtl/pedd_checker.sv
verif/tb_palette_error_diffusion_dither.sv
